// ----- rtl/nwt_pkg.sv -----
`default_nettype none

package nwt_pkg;

  // Field widths
  localparam int COORD_W    = 18;
  localparam int IDX_OUT_W  = 10;
  localparam int ABS_W      = 18;
  localparam int SQ_W       = 2 * ABS_W;
  localparam int DIST_W     = 38;
  localparam int COUNT_W    = 11;
  localparam int LIMIT_W    = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam int DEF_MAX_WAYPOINTS = 1024;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd20;

  // Command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOCATE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WAYPOINT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LIMIT   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/nwt_if.sv -----
`default_nettype none

// Request channel: load or locate command
interface nwt_req_if;
  import nwt_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [IDX_OUT_W-1:0]       entry_index;
  logic signed [COORD_W-1:0]  pos_x;
  logic signed [COORD_W-1:0]  pos_y;

  modport source (output valid, cmd, entry_index, pos_x, pos_y, input ready);
  modport sink   (input valid, cmd, entry_index, pos_x, pos_y, output ready);
endinterface

// Response channel: one beat per locate
interface nwt_rsp_if;
  import nwt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [IDX_OUT_W-1:0] nearest_index;
  logic [DIST_W-1:0]    distance_squared;
  logic                 full_scan_done;

  modport source (output valid, nearest_index, distance_squared, full_scan_done, input ready);
  modport sink   (input valid, nearest_index, distance_squared, full_scan_done, output ready);
endinterface

`default_nettype wire

// ----- rtl/nearest_waypoint_tracker_unit.sv -----
`default_nettype none

// Nearest waypoint tracker. Holds a closed path of up to MAX_WAYPOINTS (x, y)
// waypoints in an on-chip RAM, written by load commands (cmd = 0) at
// entry_index. A locate command (cmd = 1) returns the nearest waypoint index,
// its squared distance and whether the whole table was searched. The first
// locate after reset or after any load scans entries 0..count-1 and keeps the
// lowest index among equal minima; later locates start at the last answer and
// walk forward (wrapping) while the next waypoint is strictly closer, for at
// most local_search_limit steps. Loads return nothing. A locate evaluates
// one waypoint at a time through a single shared distance datapath (RAM
// read, abs difference, squares, sum and compare), issuing the next read
// only after the previous distance is compared. The request channel is
// ready again in the same cycle that the response beat becomes valid. The
// request channel is not ready while a locate is in progress; a finished
// result waits in the response register without blocking further loads,
// but the next locate holds in its last cycle until that beat is taken.
// Configuration (index 0: waypoint_count, index 1: local_search_limit) is
// to be written by the user on cfg_we only while the block is idle; the
// block itself does not enforce this. A count of zero acts as one and a
// count above MAX_WAYPOINTS is clamped to it.
module nearest_waypoint_tracker_unit #(
  parameter int MAX_WAYPOINTS = nwt_pkg::DEF_MAX_WAYPOINTS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  nwt_req_if.sink                                  request,
  nwt_rsp_if.source                                response,
  input  wire logic                                cfg_we,
  input  wire logic [nwt_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  wire logic [nwt_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import nwt_pkg::*;

  localparam int IW = $clog2(MAX_WAYPOINTS);
  localparam int CW = IW + 1;

  // Configuration registers
  logic [COUNT_W-1:0] waypoint_count;
  logic [LIMIT_W-1:0] local_search_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      waypoint_count     <= COUNT_RESET;
      local_search_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WAYPOINT_COUNT: waypoint_count     <= cfg_wdata;
        REG_SEARCH_LIMIT:   local_search_limit <= LIMIT_W'(cfg_wdata);
      endcase
    end
  end

  // Effective count: zero acts as one, clamp at table depth
  logic [CW-1:0] count_eff;

  always_comb begin
    if (waypoint_count == '0) begin
      count_eff = CW'(1);
    end else if (32'(waypoint_count) > 32'(MAX_WAYPOINTS)) begin
      count_eff = CW'(MAX_WAYPOINTS);
    end else begin
      count_eff = CW'(waypoint_count);
    end
  end

  // Sequencer state and working registers
  state_t                    state, state_next;
  logic [IW-1:0]             cur, cur_next;
  logic [IW-1:0]             best, best_next;
  logic [DIST_W-1:0]         best_d, best_d_next;
  logic [CW-1:0]             count, count_next;
  logic [LIMIT_W-1:0]        steps, steps_next;
  logic                      first, first_next;
  logic                      full, full_next;
  logic signed [COORD_W-1:0] px, py;
  logic [IW-1:0]             tracked_index;
  logic                      tracking_valid;

  logic req_fire, is_load, is_locate, finish_fire;

  assign request.ready = (state == ST_IDLE);
  assign req_fire      = request.valid && request.ready;
  assign is_load       = req_fire && (request.cmd == CMD_LOAD);
  assign is_locate     = req_fire && (request.cmd == CMD_LOCATE);
  assign finish_fire   = (state == ST_FINISH) && (!response.valid || response.ready);

  // Path table: x in the upper half, y in the lower half
  logic                     ram_we, ram_re, rd_vld;
  logic [2*COORD_W-1:0]     ram_rdata;

  assign ram_we = is_load && (32'(request.entry_index) < 32'(MAX_WAYPOINTS));
  assign ram_re = (state == ST_ISSUE);

  nwt_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (MAX_WAYPOINTS)
  ) u_path_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IW'(request.entry_index)),
    .wdata ({request.pos_x, request.pos_y}),
    .re    (ram_re),
    .raddr (cur),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= ram_re;
    end
  end

  // Shared distance datapath
  logic              d_vld;
  logic [DIST_W-1:0] d;

  nwt_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (rd_vld),
    .px      (px),
    .py      (py),
    .wx      (signed'(ram_rdata[2*COORD_W-1:COORD_W])),
    .wy      (signed'(ram_rdata[COORD_W-1:0])),
    .out_vld (d_vld),
    .dist_sq (d)
  );

  // Walk helpers
  logic [CW-1:0] cur_plus;
  logic          at_end;
  logic [IW-1:0] cur_wrap;
  logic          closer;

  assign cur_plus = CW'({1'b0, cur} + CW'(1));
  assign at_end   = (cur_plus >= count);
  assign cur_wrap = at_end ? '0 : cur_plus[IW-1:0];
  assign closer   = (d < best_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    logic done;
    logic take;
    state_next  = state;
    cur_next    = cur;
    best_next   = best;
    best_d_next = best_d;
    count_next  = count;
    steps_next  = steps;
    first_next  = first;
    full_next   = full;
    done        = 1'b0;
    take        = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (is_locate) begin
          // Full scan when nothing is tracked or the tracked entry fell off
          full_next  = !tracking_valid || ({1'b0, tracked_index} >= count_eff);
          cur_next   = full_next ? '0 : tracked_index;
          count_next = count_eff;
          steps_next = local_search_limit;
          first_next = 1'b1;
          state_next = ST_ISSUE;
        end
      end

      ST_ISSUE: begin
        state_next = ST_WAIT;
      end

      ST_WAIT: begin
        if (d_vld) begin
          first_next = 1'b0;
          if (full) begin
            // Strict compare keeps the lowest index on ties
            take = first || closer;
            done = at_end;
          end else if (first) begin
            take = 1'b1;
            done = (steps == '0);
          end else if (closer) begin
            take       = 1'b1;
            steps_next = steps - LIMIT_W'(1);
            done       = (steps == LIMIT_W'(1));
          end else begin
            done = 1'b1;
          end

          if (take) begin
            best_next   = cur;
            best_d_next = d;
          end

          if (done) begin
            state_next = ST_FINISH;
          end else begin
            cur_next   = full ? cur_plus[IW-1:0] : cur_wrap;
            state_next = ST_ISSUE;
          end
        end
      end

      ST_FINISH: begin
        if (finish_fire) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur    <= cur_next;
    best   <= best_next;
    best_d <= best_d_next;
    count  <= count_next;
    steps  <= steps_next;
    first  <= first_next;
    full   <= full_next;
    if (is_locate) begin
      px <= request.pos_x;
      py <= request.pos_y;
    end
  end

  // Tracking state: any load forces the next locate to scan
  always_ff @(posedge clk) begin
    if (rst) begin
      tracked_index  <= '0;
      tracking_valid <= 1'b0;
    end else if (is_load) begin
      tracking_valid <= 1'b0;
    end else if (finish_fire) begin
      tracked_index  <= best;
      tracking_valid <= 1'b1;
    end
  end

  // Response register; holds the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      response.valid <= 1'b0;
    end else if (finish_fire) begin
      response.valid <= 1'b1;
    end else if (response.ready) begin
      response.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_fire) begin
      response.nearest_index    <= IDX_OUT_W'(best);
      response.distance_squared <= best_d;
      response.full_scan_done   <= full;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/nwt_ram.sv -----
`default_nettype none

module nwt_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/nwt_dist.sv -----
`default_nettype none

// Squared-distance unit: abs difference, then squares, then sum.
module nwt_dist (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_vld,
  input  wire logic signed [nwt_pkg::COORD_W-1:0] px,
  input  wire logic signed [nwt_pkg::COORD_W-1:0] py,
  input  wire logic signed [nwt_pkg::COORD_W-1:0] wx,
  input  wire logic signed [nwt_pkg::COORD_W-1:0] wy,
  output      logic                               out_vld,
  output      logic [nwt_pkg::DIST_W-1:0]         dist_sq
);
  import nwt_pkg::*;

  logic signed [COORD_W:0] dx, dy;
  logic [ABS_W-1:0]        ax, ay;
  logic [SQ_W-1:0]         sqx, sqy;
  logic                    v1;

  assign dx = {px[COORD_W-1], px} - {wx[COORD_W-1], wx};
  assign dy = {py[COORD_W-1], py} - {wy[COORD_W-1], wy};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      v1      <= in_vld;
      out_vld <= v1;
    end
  end

  always_ff @(posedge clk) begin
    ax  <= dx[COORD_W] ? ABS_W'(-dx) : ABS_W'(dx);
    ay  <= dy[COORD_W] ? ABS_W'(-dy) : ABS_W'(dy);
    sqx <= ax * ax;
    sqy <= ay * ay;
  end

  assign dist_sq = DIST_W'(sqx) + DIST_W'(sqy);

endmodule

`default_nettype wire

// ----- tb/sv/nearest_waypoint_tracker_unit_tb.sv -----
`timescale 1ns / 1ps

module nearest_waypoint_tracker_unit_tb;
  import nwt_pkg::*;

  // No beat on either channel for this many cycles means a hang. It is set
  // above the slowest correct gap, a full 1024-entry scan plus the longest
  // answer stall and sender gap.
  localparam int QUIET_LIMIT = 40000;
  localparam int RANDOM_BEATS = 900;
  localparam int MAX_PRINTED = 200;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] nearest_index;
    logic [DIST_W-1:0]    distance_squared;
    logic                 full_scan_done;
  } waypoint_answer_t;

  // Mirror of the waypoint table and the tracking state. Computes the answer
  // of every accepted locate and holds it until the answer beat shows up.
  class path_tracker_mirror;
    bit signed [COORD_W-1:0] path_x [DEF_MAX_WAYPOINTS];
    bit signed [COORD_W-1:0] path_y [DEF_MAX_WAYPOINTS];
    int unsigned tracked;
    bit tracking_ok;
    int unsigned count_reg;
    int unsigned limit_reg;
    waypoint_answer_t answers_due[$];
    int unsigned mismatches;

    function new();
      tracked = 0;
      tracking_ok = 0;
      count_reg = COUNT_RESET;
      limit_reg = LIMIT_RESET;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
      if (addr == REG_WAYPOINT_COUNT) count_reg = value;
      else if (addr == REG_SEARCH_LIMIT) limit_reg = value[LIMIT_W-1:0];
    endfunction

    // zero acts as one, anything above the table size is clamped
    function int unsigned live_count();
      if (count_reg == 0) return 1;
      if (count_reg > DEF_MAX_WAYPOINTS) return DEF_MAX_WAYPOINTS;
      return count_reg;
    endfunction

    function logic [DIST_W-1:0] dist_to(logic signed [COORD_W-1:0] px,
                                        logic signed [COORD_W-1:0] py, int unsigned i);
      longint dx;
      longint dy;
      dx = longint'(px) - longint'(path_x[i]);
      dy = longint'(py) - longint'(path_y[i]);
      return DIST_W'(dx * dx + dy * dy);
    endfunction

    function void note_command(logic cmd, logic [IDX_OUT_W-1:0] entry,
                               logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py);
      int unsigned n;
      int unsigned best;
      int unsigned nxt;
      logic [DIST_W-1:0] best_d;
      logic [DIST_W-1:0] d;
      bit full;
      waypoint_answer_t ans;
      if (cmd == CMD_LOAD) begin
        path_x[entry] = px;
        path_y[entry] = py;
        tracking_ok = 0;
        return;
      end
      n = live_count();
      full = !tracking_ok || tracked >= n;
      if (full) begin
        // first lowest index wins on ties
        best = 0;
        best_d = dist_to(px, py, 0);
        for (int unsigned i = 1; i < n; i++) begin
          d = dist_to(px, py, i);
          if (d < best_d) begin
            best = i;
            best_d = d;
          end
        end
      end else begin
        // walk forward with wrap while strictly closer
        best = tracked;
        best_d = dist_to(px, py, best);
        for (int unsigned s = 0; s < limit_reg; s++) begin
          nxt = (best + 1 >= n) ? 0 : best + 1;
          d = dist_to(px, py, nxt);
          if (d < best_d) begin
            best = nxt;
            best_d = d;
          end else begin
            break;
          end
        end
      end
      tracked = best;
      tracking_ok = 1;
      ans.nearest_index = IDX_OUT_W'(best);
      ans.distance_squared = best_d;
      ans.full_scan_done = full;
      answers_due = {answers_due, ans};
    endfunction

    function void check_answer(waypoint_answer_t got);
      waypoint_answer_t want;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_PRINTED)
          $display("%0t: answer with none expected: idx %0d dist %0d full %0d", $time,
                   got.nearest_index, got.distance_squared, got.full_scan_done);
        return;
      end
      want = answers_due.pop_front();
      if (got.nearest_index !== want.nearest_index) begin
        mismatches++;
        if (mismatches <= MAX_PRINTED)
          $display("%0t: nearest_index expected %0d actual %0d", $time,
                   want.nearest_index, got.nearest_index);
      end
      if (got.distance_squared !== want.distance_squared) begin
        mismatches++;
        if (mismatches <= MAX_PRINTED)
          $display("%0t: distance_squared expected %0d actual %0d", $time,
                   want.distance_squared, got.distance_squared);
      end
      if (got.full_scan_done !== want.full_scan_done) begin
        mismatches++;
        if (mismatches <= MAX_PRINTED)
          $display("%0t: full_scan_done expected %0d actual %0d", $time,
                   want.full_scan_done, got.full_scan_done);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  nwt_req_if request_ch ();
  nwt_rsp_if answer_ch ();

  path_tracker_mirror board;
  int burst_left = 0;
  int beats_sent = 0;

  nearest_waypoint_tracker_unit dut (
    .clk      (clk),
    .rst      (rst),
    .request  (request_ch),
    .response (answer_ch),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Beat monitor: both channels sampled at the rising edge. An answer always
  // belongs to an older locate, so it is checked before a new command is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (answer_ch.valid && answer_ch.ready)
        board.check_answer('{answer_ch.nearest_index, answer_ch.distance_squared,
                             answer_ch.full_scan_done});
      if (request_ch.valid && request_ch.ready)
        board.note_command(request_ch.cmd, request_ch.entry_index,
                           request_ch.pos_x, request_ch.pos_y);
    end
  end

  // Answer side stalls on its own pattern: stretches of always-ready,
  // coin-flip ready, and mostly-stalled.
  initial begin : answer_stall
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    answer_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 150);
      end
      mode_left--;
      case (mode)
        0: begin
          answer_ch.ready = 1'b1;
        end
        1: begin
          answer_ch.ready = 1'($urandom_range(0, 1));
        end
        default: begin
          answer_ch.ready = ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst === 1'b0);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((request_ch.valid && request_ch.ready) || (answer_ch.valid && answer_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  function automatic int clamp_coord(longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return int'(v);
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(0, 262143)) - 131072;
  endfunction

  // One request beat. Called and returns at a falling edge; valid stays high
  // on return so a burst runs back to back. Gaps open at burst boundaries.
  task automatic send_beat(logic cmd, logic [IDX_OUT_W-1:0] entry, int x, int y);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        request_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    request_ch.cmd = cmd;
    request_ch.entry_index = entry;
    request_ch.pos_x = COORD_W'(x);
    request_ch.pos_y = COORD_W'(y);
    request_ch.valid = 1'b1;
    do @(posedge clk); while (!request_ch.ready);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic load_waypoint(int entry, int x, int y);
    send_beat(CMD_LOAD, IDX_OUT_W'(entry), x, y);
  endtask

  // entry_index is don't-care on a locate, so it gets noise
  task automatic locate_vehicle(int x, int y);
    send_beat(CMD_LOCATE, IDX_OUT_W'($urandom_range(0, 1023)), x, y);
  endtask

  // Sender goes quiet until every answer is back and a trailing load has landed.
  task automatic drain_answers();
    request_ch.valid = 1'b0;
    burst_left = 0;
    while (board.answers_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_register(logic [CFG_IDX_W-1:0] addr, int value);
    drain_answers();
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_wdata = CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    board.write_reg(addr, CFG_DATA_W'(value));
  endtask

  // Fill entries 0..n-1 with one of several path shapes:
  // straight-ish drive, full-range scatter, tied points, circle.
  task automatic load_path(int n, int shape);
    int cx;
    int cy;
    int sx;
    int sy;
    longint x;
    longint y;
    real r;
    real ang;
    cx = $urandom_range(0, 200000) - 100000;
    cy = $urandom_range(0, 200000) - 100000;
    sx = $urandom_range(0, 4000) - 2000;
    sy = $urandom_range(0, 4000) - 2000;
    r = $urandom_range(500, 100000);
    x = cx;
    y = cy;
    for (int i = 0; i < n; i++) begin
      case (shape)
        0: begin
          x = clamp_coord(x + sx + $urandom_range(0, 400) - 200);
          y = clamp_coord(y + sy + $urandom_range(0, 400) - 200);
        end
        1: begin
          x = any_coord();
          y = any_coord();
        end
        2: begin
          // few distinct spots, lots of equal distances
          x = cx + 500 * $urandom_range(0, 2);
          y = cy + 500 * $urandom_range(0, 1);
        end
        default: begin
          ang = 6.283185307 * i / n;
          x = clamp_coord(cx + longint'(r * $cos(ang)));
          y = clamp_coord(cy + longint'(r * $sin(ang)));
        end
      endcase
      load_waypoint(i, int'(x), int'(y));
    end
  endtask

  // Vehicle drives forward along the loaded path, mostly by less than the
  // search limit; noise adds off-path positions and stray reloads.
  task automatic track_along(int n, int nloc, bit noisy);
    int k;
    int pick;
    int lim;
    k = $urandom_range(0, n - 1);
    lim = board.limit_reg;
    repeat (nloc) begin
      pick = noisy ? $urandom_range(0, 19) : 19;
      if (pick == 0) begin
        load_waypoint($urandom_range(0, 1023), any_coord(), any_coord());
      end else if (pick < 3) begin
        locate_vehicle(any_coord(), any_coord());
      end else begin
        k = (k + $urandom_range(0, lim + 2)) % n;
        locate_vehicle(clamp_coord(longint'(board.path_x[k]) + $urandom_range(0, 600) - 300),
                       clamp_coord(longint'(board.path_y[k]) + $urandom_range(0, 600) - 300));
      end
      if (noisy && $urandom_range(0, 49) == 0)
        drain_answers();
    end
  endtask

  task automatic run_path_phase();
    int n;
    int old_n;
    int pick;
    old_n = board.live_count();
    pick = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0 && old_n > 1) begin
      // shrink the count over a loaded table: tracked index may go stale
      n = $urandom_range(1, old_n - 1);
      set_register(REG_WAYPOINT_COUNT, n);
    end else begin
      if (pick < 6) n = $urandom_range(1, 16);
      else if (pick < 9) n = $urandom_range(17, 120);
      else n = $urandom_range(121, 400);
      set_register(REG_WAYPOINT_COUNT, (n == 1 && $urandom_range(0, 1) == 1) ? 0 : n);
      load_path(n, $urandom_range(0, 3));
    end
    pick = $urandom_range(0, 5);
    case (pick)
      0: set_register(REG_SEARCH_LIMIT, 0);
      1: set_register(REG_SEARCH_LIMIT, 63);
      2: set_register(REG_SEARCH_LIMIT, 1);
      default: set_register(REG_SEARCH_LIMIT, $urandom_range(0, 63));
    endcase
    track_along(n, $urandom_range(5, 60), 1'b1);
  endtask

  initial begin : main
    int start_beats;
    board = new();
    request_ch.valid = 1'b0;
    request_ch.cmd = CMD_LOAD;
    request_ch.entry_index = '0;
    request_ch.pos_x = '0;
    request_ch.pos_y = '0;
    cfg_we = 1'b0;
    cfg_addr = REG_WAYPOINT_COUNT;
    cfg_wdata = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed part, reset config (count 1, limit 20) ---
    load_waypoint(0, -131072, -131072);
    locate_vehicle(131071, 131071);         // first locate: full scan, largest distance
    locate_vehicle(-131072, -131072);       // tracking on a one-entry path wraps onto itself
    load_waypoint(1023, 131071, 131071);    // top entry, load drops tracking
    locate_vehicle(0, 0);
    set_register(REG_WAYPOINT_COUNT, 0);    // zero count behaves as one
    locate_vehicle(1, -1);
    set_register(REG_WAYPOINT_COUNT, 4);
    set_register(REG_SEARCH_LIMIT, 0);
    load_waypoint(0, 0, 0);
    load_waypoint(1, 100, 0);
    load_waypoint(2, 200, 0);
    load_waypoint(3, 100, 0);               // same spot as entry 1
    locate_vehicle(100, 0);                 // tie in full scan: lowest index
    locate_vehicle(200, 0);                 // zero limit: stays on remembered entry
    set_register(REG_SEARCH_LIMIT, 63);
    locate_vehicle(200, 0);
    locate_vehicle(100, 0);                 // moves only on strictly closer
    locate_vehicle(0, 0);                   // wraps from last entry to 0
    locate_vehicle(200, 0);
    set_register(REG_WAYPOINT_COUNT, 2);    // tracked index now past the count
    locate_vehicle(200, 0);
    set_register(REG_SEARCH_LIMIT, 1);
    locate_vehicle(0, 0);

    // --- full table: saturating count and the largest legal count ---
    set_register(REG_SEARCH_LIMIT, 63);
    set_register(REG_WAYPOINT_COUNT, 1024);
    load_path(1024, ($urandom_range(0, 1) == 1) ? 0 : 3);
    set_register(REG_WAYPOINT_COUNT, 2047);
    track_along(1024, 4, 1'b0);
    set_register(REG_WAYPOINT_COUNT, 1024);
    track_along(1024, 4, 1'b0);

    // --- random path phases ---
    start_beats = beats_sent;
    while (beats_sent - start_beats < RANDOM_BEATS)
      run_path_phase();

    drain_answers();
    repeat (20) @(negedge clk);
    if (board.mismatches == 0 && board.answers_due.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
